// ===== hdl/lruc_pkg.sv =====
// Shared types and constants for the LRU cache hit/miss counter.
// Used by the interfaces, the register block, front, back and top level.
package lruc_pkg;

   localparam int DEF_MAX_SET_BITS = 6;
   localparam int DEF_MAX_WAYS     = 8;
   localparam int TAG_W            = 64;
   localparam int QUEUE_DEPTH      = 2;
   localparam int CSR_ADDR_W       = 4;
   localparam int CSR_DATA_W       = 32;
   localparam int COUNT_W          = 32;

   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_STORE  = 2'd1;
   localparam logic [1:0] REQ_MODIFY = 2'd2;

   localparam logic [1:0] OUTCOME_HIT   = 2'd0;
   localparam logic [1:0] OUTCOME_FILL  = 2'd1;
   localparam logic [1:0] OUTCOME_EVICT = 2'd2;

   localparam logic [1:0] REG_SET_BITS    = 2'd0;
   localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
   localparam logic [1:0] REG_WAYS        = 2'd2;

   localparam logic [2:0] RST_SET_BITS    = 3'd4;
   localparam logic [4:0] RST_OFFSET_BITS = 5'd4;
   localparam logic [3:0] RST_WAYS        = 4'd8;

   typedef struct packed {
      logic [2:0] set_index_bits;
      logic [4:0] offset_bits;
      logic [3:0] ways_in_use;
   } lruc_cfg_type;

endpackage

// ===== hdl/lruc_intf.sv =====
// Valid/ready channel interfaces for access requests and results.
// Depends on lruc_pkg for field widths.
interface lruc_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 req_type;
   logic [lruc_pkg::TAG_W-1:0] address;

   modport source (output valid, output req_type, output address, input ready);
   modport sink   (input valid, input req_type, input address, output ready);
endinterface

interface lruc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   outcome;
   logic [lruc_pkg::COUNT_W-1:0] hit_total;
   logic [lruc_pkg::COUNT_W-1:0] miss_total;
   logic [lruc_pkg::COUNT_W-1:0] eviction_total;

   modport source (output valid, output outcome, output hit_total, output miss_total,
                   output eviction_total, input ready);
   modport sink   (input valid, input outcome, input hit_total, input miss_total,
                   input eviction_total, output ready);
endinterface

// ===== hdl/lruc_csr.sv =====
// APB-style configuration registers: set bits, offset bits, ways in use.
// Raises a flush on every write to a known register. Depends on lruc_pkg.
module lruc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lruc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [lruc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [lruc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output lruc_pkg::lruc_cfg_type            cfg,
   output logic                              flush
);
   import lruc_pkg::*;

   logic [2:0] set_bits_ff, set_bits_in;
   logic [4:0] offset_bits_ff, offset_bits_in;
   logic [3:0] ways_ff, ways_in;
   logic       wr_strobe;
   logic [1:0] reg_idx;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[3:2];
   assign wr_strobe = psel & penable & pwrite;
   assign flush     = wr_strobe & ((reg_idx == REG_SET_BITS) || (reg_idx == REG_OFFSET_BITS) ||
                                   (reg_idx == REG_WAYS));

   always_comb begin
      set_bits_in    = set_bits_ff;
      offset_bits_in = offset_bits_ff;
      ways_in        = ways_ff;
      if (wr_strobe) begin
         case (reg_idx)
            REG_SET_BITS:    set_bits_in    = pwdata[2:0];
            REG_OFFSET_BITS: offset_bits_in = pwdata[4:0];
            REG_WAYS:        ways_in        = pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff    <= RST_SET_BITS;
         offset_bits_ff <= RST_OFFSET_BITS;
         ways_ff        <= RST_WAYS;
      end else begin
         set_bits_ff    <= set_bits_in;
         offset_bits_ff <= offset_bits_in;
         ways_ff        <= ways_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_SET_BITS:    prdata = {29'd0, set_bits_ff};
         REG_OFFSET_BITS: prdata = {27'd0, offset_bits_ff};
         REG_WAYS:        prdata = {28'd0, ways_ff};
         default:         prdata = '0;
      endcase
   end

   assign cfg.set_index_bits = set_bits_ff;
   assign cfg.offset_bits    = offset_bits_ff;
   assign cfg.ways_in_use    = ways_ff;

endmodule

// ===== hdl/lruc_front.sv =====
// Front end: accepts requests, splits the address into set and tag,
// clamps the way count and packs a work item for the queue. Depends on lruc_pkg.
module lruc_front #(
   parameter  int MAX_SET_BITS = lruc_pkg::DEF_MAX_SET_BITS,
   parameter  int MAX_WAYS     = lruc_pkg::DEF_MAX_WAYS,
   localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
   localparam int WC_W         = $clog2(MAX_WAYS + 1),
   localparam int ITEM_W       = 1 + SET_W + lruc_pkg::TAG_W + WC_W
) (
   lruc_req_if.sink                req_bus,
   input  lruc_pkg::lruc_cfg_type  cfg,
   input  logic                    q_space,
   output logic                    q_push,
   output logic [ITEM_W-1:0]       q_item
);
   import lruc_pkg::*;

   logic [3:0]       s_eff;
   logic [5:0]       shamt;
   logic [TAG_W-1:0] tag;
   logic [TAG_W-1:0] off_shift;
   logic [SET_W-1:0] set_idx;
   logic [WC_W-1:0]  ways_eff;
   logic             modify;

   always_comb begin
      if (32'(cfg.set_index_bits) > MAX_SET_BITS) begin
         s_eff = 4'(MAX_SET_BITS);
      end else begin
         s_eff = 4'(cfg.set_index_bits);
      end
      shamt     = 6'(s_eff) + 6'(cfg.offset_bits);
      tag       = req_bus.address >> shamt;
      off_shift = req_bus.address >> cfg.offset_bits;
      for (int i = 0; i < SET_W; i++) begin
         set_idx[i] = off_shift[i] & (i < 32'(s_eff));
      end
      if (cfg.ways_in_use == 4'd0) begin
         ways_eff = WC_W'(1);
      end else if (32'(cfg.ways_in_use) > MAX_WAYS) begin
         ways_eff = WC_W'(MAX_WAYS);
      end else begin
         ways_eff = WC_W'(cfg.ways_in_use);
      end
      modify = (req_bus.req_type == REQ_MODIFY);
   end

   assign req_bus.ready = q_space;
   assign q_push        = req_bus.valid & q_space;
   assign q_item        = {modify, set_idx, tag, ways_eff};

endmodule

// ===== hdl/lruc_queue.sv =====
// Short FIFO between the front end and the back end.
// Generic width and depth; no package dependency.
module lruc_queue #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 2,
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW    = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             space,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);
   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign space      = (count_ff != CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/lruc_back.sv =====
// Back end: reads one set's tags and recency ranks, resolves hit, fill or
// eviction, writes the set back and keeps the saturating totals. Depends on lruc_pkg.
module lruc_back #(
   parameter  int MAX_SET_BITS = lruc_pkg::DEF_MAX_SET_BITS,
   parameter  int MAX_WAYS     = lruc_pkg::DEF_MAX_WAYS,
   localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1,
   localparam int WC_W         = $clog2(MAX_WAYS + 1),
   localparam int ITEM_W       = 1 + SET_W + lruc_pkg::TAG_W + WC_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              flush,
   input  logic              q_valid,
   input  logic [ITEM_W-1:0] q_item,
   output logic              q_pop,
   lruc_rsp_if.source        rsp_bus
);
   import lruc_pkg::*;

   localparam int ROWS  = 2 ** SET_W;
   localparam int AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WI_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic {ST_IDLE, ST_LOOK} state_type;

   logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem [ROWS];
   logic [MAX_WAYS-1:0]            vld_mem [ROWS];
   logic [MAX_WAYS-1:0][AGE_W-1:0] age_mem [ROWS];
   logic [ROWS-1:0]                row_valid_ff;

   logic [MAX_WAYS-1:0][TAG_W-1:0] tag_rd_ff;
   logic [MAX_WAYS-1:0]            vld_rd_ff;
   logic [MAX_WAYS-1:0][AGE_W-1:0] age_rd_ff;
   logic                           rowv_rd_ff;
   logic [ITEM_W-1:0]              cur_ff;

   logic [SET_W-1:0] q_set;
   logic             cur_modify;
   logic [SET_W-1:0] cur_set;
   logic [TAG_W-1:0] cur_tag;
   logic [WC_W-1:0]  cur_ways;
   logic [WC_W-1:0]  ways_m1;

   logic [MAX_WAYS-1:0]            in_use, lv, match, free, vict;
   logic [MAX_WAYS-1:0][AGE_W-1:0] la;
   logic                           hit_any, free_any;
   logic [WI_W-1:0]                hit_idx, free_idx, vict_idx, sel_idx;
   logic                           fill;
   logic [AGE_W-1:0]               old_age;
   logic [MAX_WAYS-1:0][TAG_W-1:0] tags_new;
   logic [MAX_WAYS-1:0]            vld_new;
   logic [MAX_WAYS-1:0][AGE_W-1:0] ages_new;
   logic [1:0]                     hit_inc;
   logic [COUNT_W:0]               hit_sum;

   state_type          state_ff, state_in;
   logic               out_valid_ff, out_valid_in;
   logic [1:0]         outcome_ff, outcome_in;
   logic [COUNT_W-1:0] hits_ff, hits_in;
   logic [COUNT_W-1:0] misses_ff, misses_in;
   logic [COUNT_W-1:0] evicts_ff, evicts_in;
   logic               mem_we;

   assign q_set      = q_item[ITEM_W-2 -: SET_W];
   assign cur_modify = cur_ff[ITEM_W-1];
   assign cur_set    = cur_ff[ITEM_W-2 -: SET_W];
   assign cur_tag    = cur_ff[WC_W +: TAG_W];
   assign cur_ways   = cur_ff[WC_W-1:0];
   assign ways_m1    = cur_ways - 1'b1;

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w] = (WC_W'(w) < cur_ways);
         lv[w]     = rowv_rd_ff & vld_rd_ff[w];
         la[w]     = rowv_rd_ff ? age_rd_ff[w] : '0;
         match[w]  = in_use[w] & lv[w] & (tag_rd_ff[w] == cur_tag);
         free[w]   = in_use[w] & ~lv[w];
         vict[w]   = in_use[w] & (la[w] == AGE_W'(ways_m1));
      end
      hit_any  = 1'b0;
      free_any = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      vict_idx = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_any = 1'b1;
            hit_idx = WI_W'(w);
         end
         if (free[w]) begin
            free_any = 1'b1;
            free_idx = WI_W'(w);
         end
         if (vict[w]) begin
            vict_idx = WI_W'(w);
         end
      end
      fill = ~hit_any & free_any;
      if (hit_any) begin
         sel_idx = hit_idx;
      end else if (free_any) begin
         sel_idx = free_idx;
      end else begin
         sel_idx = vict_idx;
      end
      old_age = la[sel_idx];
      for (int v = 0; v < MAX_WAYS; v++) begin
         tags_new[v] = tag_rd_ff[v];
         vld_new[v]  = lv[v];
         ages_new[v] = la[v];
         if (WI_W'(v) == sel_idx) begin
            vld_new[v]  = 1'b1;
            ages_new[v] = '0;
            if (!hit_any) begin
               tags_new[v] = cur_tag;
            end
         end else if (in_use[v] && lv[v] && (fill || (la[v] < old_age)) &&
                      (la[v] < AGE_MAX)) begin
            ages_new[v] = la[v] + 1'b1;
         end
      end
      hit_inc = {1'b0, hit_any} + {1'b0, cur_modify};
      hit_sum = {1'b0, hits_ff} + (COUNT_W + 1)'(hit_inc);
   end

   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff & ~rsp_bus.ready;
      outcome_in   = outcome_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evicts_in    = evicts_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && (!out_valid_ff || rsp_bus.ready)) begin
               q_pop    = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            mem_we       = 1'b1;
            out_valid_in = 1'b1;
            hits_in      = hit_sum[COUNT_W] ? COUNT_MAX : hit_sum[COUNT_W-1:0];
            if (hit_any) begin
               outcome_in = OUTCOME_HIT;
            end else begin
               outcome_in = fill ? OUTCOME_FILL : OUTCOME_EVICT;
               misses_in  = (misses_ff == COUNT_MAX) ? COUNT_MAX : misses_ff + 1'b1;
               if (!fill) begin
                  evicts_in = (evicts_ff == COUNT_MAX) ? COUNT_MAX : evicts_ff + 1'b1;
               end
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evicts_ff    <= evicts_in;
      end
      outcome_ff <= outcome_in;
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         row_valid_ff <= '0;
      end else if (mem_we) begin
         row_valid_ff[cur_set] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         tag_rd_ff  <= tag_mem[q_set];
         vld_rd_ff  <= vld_mem[q_set];
         age_rd_ff  <= age_mem[q_set];
         rowv_rd_ff <= row_valid_ff[q_set];
         cur_ff     <= q_item;
      end
      if (mem_we) begin
         tag_mem[cur_set] <= tags_new;
         vld_mem[cur_set] <= vld_new;
         age_mem[cur_set] <= ages_new;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.outcome        = outcome_ff;
   assign rsp_bus.hit_total      = hits_ff;
   assign rsp_bus.miss_total     = misses_ff;
   assign rsp_bus.eviction_total = evicts_ff;

endmodule

// ===== hdl/lru_cache_hit_miss_counter_unit.sv =====
// Set-associative LRU cache model: counts hits, misses and evictions for a
// stream of load, store and modify accesses. The back end's idle state reads the
// addressed set's tags, valid bits and recency ranks from the set memory; its
// look state resolves the lookup, writes the set back and loads the result
// register. A new access is popped only once no result waits or it is being
// read. A two-entry queue behind the front end keeps taking requests while a
// result waits. Any write to a configuration register invalidates every line
// at once through per-set valid flags (no clearing pass); the totals are kept
// and saturate at all ones. Depends on lruc_pkg and the channel interfaces.
module lru_cache_hit_miss_counter_unit #(
   parameter int MAX_SET_BITS = lruc_pkg::DEF_MAX_SET_BITS,
   parameter int MAX_WAYS     = lruc_pkg::DEF_MAX_WAYS
) (
   input  logic                            clock,
   input  logic                            reset,
   lruc_req_if.sink                        req_bus,
   lruc_rsp_if.source                      rsp_bus,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lruc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [lruc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [lruc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import lruc_pkg::*;

   localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WC_W   = $clog2(MAX_WAYS + 1);
   localparam int ITEM_W = 1 + SET_W + TAG_W + WC_W;

   lruc_cfg_type      cfg;
   logic              flush;
   logic              q_space;
   logic              q_push;
   logic [ITEM_W-1:0] q_item;
   logic              q_pop;
   logic              q_valid;
   logic [ITEM_W-1:0] q_head;

   lruc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .flush   (flush)
   );

   lruc_front #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS)
   ) u_front (
      .req_bus (req_bus),
      .cfg     (cfg),
      .q_space (q_space),
      .q_push  (q_push),
      .q_item  (q_item)
   );

   lruc_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_item),
      .space      (q_space),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   lruc_back #(
      .MAX_SET_BITS (MAX_SET_BITS),
      .MAX_WAYS     (MAX_WAYS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .flush   (flush),
      .q_valid (q_valid),
      .q_item  (q_head),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule
